@@ rtl/apr_pkg.sv @@
// Shared types and constants for the affine pixel remap core.
package apr_pkg;

  // Fixed field widths
  localparam int COEF_W  = 26;               // signed coefficient width
  localparam int SIZE_W  = 9;                // image size register width
  localparam int PIX_W   = 8;                // pixel value and coordinate width
  localparam int PROD_W  = COEF_W + PIX_W + 1;   // coordinate times coefficient
  localparam int TGT_W   = PROD_W + 2;       // sum of two products and an offset
  localparam int CFG_W   = COEF_W;           // widest register
  localparam int CFG_IDX_W = 3;

  // Parameter defaults
  localparam int MAX_ROWS_DEF  = 256;
  localparam int MAX_COLS_DEF  = 256;
  localparam int FRAC_BITS_DEF = 14;

  // Register reset values (identity transform, full image)
  localparam logic signed [COEF_W-1:0] COEF_UNIT_RST = 26'sd16384;
  localparam logic [SIZE_W-1:0]        SIZE_RST      = 9'd256;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_C_RR       = 3'd0,
    CFG_C_RC       = 3'd1,
    CFG_C_R0       = 3'd2,
    CFG_C_CR       = 3'd3,
    CFG_C_CC       = 3'd4,
    CFG_C_C0       = 3'd5,
    CFG_IMAGE_ROWS = 3'd6,
    CFG_IMAGE_COLS = 3'd7
  } cfg_idx_t;

  // Request actions
  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_FETCH = 2'd1,
    ACT_FWD   = 2'd2
  } action_t;

  typedef struct packed {
    logic [1:0]       action;
    logic [PIX_W-1:0] pix_row;
    logic [PIX_W-1:0] pix_col;
    logic [PIX_W-1:0] pix_value;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] value_out;
    logic [PIX_W-1:0] target_row;
    logic [PIX_W-1:0] target_col;
    logic             in_range;
  } out_item_t;

endpackage

@@ rtl/affine_pixel_remap_core.sv @@
// Top level of the affine pixel remap core: five-stage pipeline with image store.
//
// Nearest-neighbour affine remap of 8-bit images. Each request (load, backward
// fetch or forward map) enters on in_valid/in_stall and yields exactly one result
// on out_valid/out_stall, in order. One request is taken every clock cycle while
// the result channel is not stalled. A result passes through the five register
// stages, the first of which loads at the accepting edge (coefficient products,
// target sums, range test and rounding, store address, store access with output
// register). The image store has one write and one read port, both used at the
// last stage, so a load is seen by every later fetch. A stalled output holds the
// pipeline only where stages are full; bubbles close up. The user must write
// coefficients and sizes through cfg_* only while no request is in flight; the
// block itself does not enforce this. Store entries never loaded read as garbage.
module affine_pixel_remap_core #(
  parameter int MAX_ROWS  = apr_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS  = apr_pkg::MAX_COLS_DEF,
  parameter int FRAC_BITS = apr_pkg::FRAC_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // configuration
  input  logic                                   cfg_we,
  input  logic [apr_pkg::CFG_IDX_W-1:0]          cfg_idx,
  input  logic [apr_pkg::CFG_W-1:0]              cfg_wdata,
  // request channel
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  apr_pkg::in_item_t                      in_data,
  // result channel
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output apr_pkg::out_item_t                     out_data
);
  import apr_pkg::*;

  localparam int RIW   = (MAX_ROWS > 2) ? $clog2(MAX_ROWS) : 1;
  localparam int CIW   = (MAX_COLS > 2) ? $clog2(MAX_COLS) : 1;
  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = $clog2(DEPTH);

  // Stage records
  typedef struct packed {
    logic [1:0]              action;
    logic [PIX_W-1:0]        row;
    logic [PIX_W-1:0]        col;
    logic [PIX_W-1:0]        val;
    logic                    ld_ok;
    logic signed [PROD_W-1:0] p_rr;
    logic signed [PROD_W-1:0] p_rc;
    logic signed [PROD_W-1:0] p_cr;
    logic signed [PROD_W-1:0] p_cc;
  } sa_t;

  typedef struct packed {
    logic [1:0]              action;
    logic [PIX_W-1:0]        row;
    logic [PIX_W-1:0]        col;
    logic [PIX_W-1:0]        val;
    logic                    ld_ok;
    logic signed [TGT_W-1:0] ty;
    logic signed [TGT_W-1:0] tx;
  } sb_t;

  typedef struct packed {
    out_item_t       res;
    logic            use_mem;
    logic            wr;
    logic [RIW-1:0]  ridx;
    logic [CIW-1:0]  cidx;
  } sc_t;

  typedef struct packed {
    out_item_t       res;
    logic            use_mem;
    logic            wr;
    logic [AW-1:0]   addr;
  } sd_t;

  typedef struct packed {
    out_item_t       res;
    logic            use_mem;
  } se_t;

  // Configuration registers
  logic signed [COEF_W-1:0] c_rr_r, c_rc_r, c_r0_r, c_cr_r, c_cc_r, c_c0_r;
  logic [SIZE_W-1:0]        rows_r, cols_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_rr_r <= COEF_UNIT_RST;
      c_rc_r <= '0;
      c_r0_r <= '0;
      c_cr_r <= '0;
      c_cc_r <= COEF_UNIT_RST;
      c_c0_r <= '0;
      rows_r <= SIZE_RST;
      cols_r <= SIZE_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_idx))
        CFG_C_RR:       c_rr_r <= cfg_wdata;
        CFG_C_RC:       c_rc_r <= cfg_wdata;
        CFG_C_R0:       c_r0_r <= cfg_wdata;
        CFG_C_CR:       c_cr_r <= cfg_wdata;
        CFG_C_CC:       c_cc_r <= cfg_wdata;
        CFG_C_C0:       c_c0_r <= cfg_wdata;
        CFG_IMAGE_ROWS: rows_r <= cfg_wdata[SIZE_W-1:0];
        CFG_IMAGE_COLS: cols_r <= cfg_wdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective sizes: zero acts as one, clamp to the store dimensions
  logic [SIZE_W-1:0]        eff_rows, eff_cols;
  logic signed [TGT_W-1:0]  hi_row, hi_col, half;

  always_comb begin
    if (rows_r == '0)                       eff_rows = SIZE_W'(1);
    else if (32'(rows_r) > MAX_ROWS)        eff_rows = SIZE_W'(MAX_ROWS);
    else                                    eff_rows = rows_r;
    if (cols_r == '0)                       eff_cols = SIZE_W'(1);
    else if (32'(cols_r) > MAX_COLS)        eff_cols = SIZE_W'(MAX_COLS);
    else                                    eff_cols = cols_r;
    hi_row = TGT_W'({eff_rows - SIZE_W'(1), {FRAC_BITS{1'b0}}});
    hi_col = TGT_W'({eff_cols - SIZE_W'(1), {FRAC_BITS{1'b0}}});
    half   = TGT_W'(1) <<< (FRAC_BITS - 1);
  end

  // Stage valids and flow control: a stage takes new data when empty or draining
  logic va_r, vb_r, vc_r, vd_r, ve_r;
  logic rdy_a, rdy_b, rdy_c, rdy_d, rdy_e;

  assign rdy_e    = !ve_r || !out_stall;
  assign rdy_d    = !vd_r || rdy_e;
  assign rdy_c    = !vc_r || rdy_d;
  assign rdy_b    = !vb_r || rdy_c;
  assign rdy_a    = !va_r || rdy_b;
  assign in_stall = !rdy_a;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
      ve_r <= 1'b0;
    end else begin
      if (rdy_a) va_r <= in_valid;
      if (rdy_b) vb_r <= va_r;
      if (rdy_c) vc_r <= vb_r;
      if (rdy_d) vd_r <= vc_r;
      if (rdy_e) ve_r <= vd_r;
    end
  end

  // Stage A: coefficient products and load bounds check
  sa_t sa_nxt, sa_r;
  logic signed [PROD_W-1:0] row_s, col_s;

  always_comb begin
    row_s          = PROD_W'($signed({1'b0, in_data.pix_row}));
    col_s          = PROD_W'($signed({1'b0, in_data.pix_col}));
    sa_nxt.action  = in_data.action;
    sa_nxt.row     = in_data.pix_row;
    sa_nxt.col     = in_data.pix_col;
    sa_nxt.val     = in_data.pix_value;
    sa_nxt.ld_ok   = (SIZE_W'(in_data.pix_row) < eff_rows) &&
                     (SIZE_W'(in_data.pix_col) < eff_cols);
    sa_nxt.p_rr    = row_s * PROD_W'(c_rr_r);
    sa_nxt.p_rc    = col_s * PROD_W'(c_rc_r);
    sa_nxt.p_cr    = row_s * PROD_W'(c_cr_r);
    sa_nxt.p_cc    = col_s * PROD_W'(c_cc_r);
  end

  always_ff @(posedge clk) begin
    if (rdy_a && in_valid) sa_r <= sa_nxt;
  end

  // Stage B: target sums
  sb_t sb_nxt, sb_r;

  always_comb begin
    sb_nxt.action = sa_r.action;
    sb_nxt.row    = sa_r.row;
    sb_nxt.col    = sa_r.col;
    sb_nxt.val    = sa_r.val;
    sb_nxt.ld_ok  = sa_r.ld_ok;
    sb_nxt.ty     = TGT_W'(sa_r.p_rr) + TGT_W'(sa_r.p_rc) + TGT_W'(c_r0_r);
    sb_nxt.tx     = TGT_W'(sa_r.p_cr) + TGT_W'(sa_r.p_cc) + TGT_W'(c_c0_r);
  end

  always_ff @(posedge clk) begin
    if (rdy_b && va_r) sb_r <= sb_nxt;
  end

  // Stage C: range test, round half up, result selection
  sc_t sc_nxt, sc_r;
  logic                    in_r;
  logic [TGT_W-1:0]        rs_row, rs_col, rnd_row, rnd_col;

  always_comb begin
    in_r    = (sb_r.ty >= 0) && (sb_r.ty <= hi_row) &&
              (sb_r.tx >= 0) && (sb_r.tx <= hi_col);
    rs_row  = sb_r.ty + half;
    rs_col  = sb_r.tx + half;
    rnd_row = rs_row >> FRAC_BITS;
    rnd_col = rs_col >> FRAC_BITS;

    sc_nxt         = '0;
    sc_nxt.ridx    = RIW'(rnd_row);
    sc_nxt.cidx    = CIW'(rnd_col);
    case (action_t'(sb_r.action))
      ACT_LOAD: begin
        sc_nxt.res.value_out  = sb_r.val;
        sc_nxt.res.target_row = sb_r.row;
        sc_nxt.res.target_col = sb_r.col;
        sc_nxt.res.in_range   = sb_r.ld_ok;
        sc_nxt.wr             = sb_r.ld_ok;
        sc_nxt.ridx           = RIW'(sb_r.row);
        sc_nxt.cidx           = CIW'(sb_r.col);
      end
      ACT_FETCH: begin
        sc_nxt.res.target_row = in_r ? PIX_W'(rnd_row) : '0;
        sc_nxt.res.target_col = in_r ? PIX_W'(rnd_col) : '0;
        sc_nxt.res.in_range   = in_r;
        sc_nxt.use_mem        = in_r;
      end
      ACT_FWD: begin
        sc_nxt.res.value_out  = sb_r.val;
        sc_nxt.res.target_row = in_r ? PIX_W'(rnd_row) : '0;
        sc_nxt.res.target_col = in_r ? PIX_W'(rnd_col) : '0;
        sc_nxt.res.in_range   = in_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rdy_c && vb_r) sc_r <= sc_nxt;
  end

  // Stage D: store address
  sd_t sd_nxt, sd_r;

  always_comb begin
    sd_nxt.res     = sc_r.res;
    sd_nxt.use_mem = sc_r.use_mem;
    sd_nxt.wr      = sc_r.wr;
    sd_nxt.addr    = AW'(sc_r.ridx) * AW'(MAX_COLS) + AW'(sc_r.cidx);
  end

  always_ff @(posedge clk) begin
    if (rdy_d && vc_r) sd_r <= sd_nxt;
  end

  // Stage E: image store access and output register
  logic [PIX_W-1:0] store_mem [DEPTH];
  logic [PIX_W-1:0] rd_r;
  se_t              se_r;

  always_ff @(posedge clk) begin
    if (rdy_e && vd_r && sd_r.wr) store_mem[sd_r.addr] <= sd_r.res.value_out;
  end

  always_ff @(posedge clk) begin
    if (rdy_e && vd_r) begin
      rd_r          <= store_mem[sd_r.addr];
      se_r.res      <= sd_r.res;
      se_r.use_mem  <= sd_r.use_mem;
    end
  end

  always_comb begin
    out_data           = se_r.res;
    if (se_r.use_mem) out_data.value_out = rd_r;
  end

  assign out_valid = ve_r;

endmodule

@@ rtl/apr_checker.sv @@
// Port-level checks for the affine pixel remap core, bound to the top level.
module apr_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input apr_pkg::out_item_t out_data
);

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("result changed while stalled");

  // When the output drains the pipeline always moves, so requests are taken
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid || !out_stall) |-> !in_stall)
    else $error("request stalled with free output");

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered after reset");

endmodule

bind affine_pixel_remap_core apr_checker u_apr_checker (.*);
